FILE: rtl/core/pfw_pkg.sv
package pfw_pkg;

  // Table geometry
  localparam int MAX_BOUNDS = 8;
  localparam int IDX_W      = $clog2(MAX_BOUNDS);
  localparam int CNT_W      = $clog2(MAX_BOUNDS + 1);

  // Field widths
  localparam int COUNT_W  = 7;
  localparam int LENGTH_W = 15;
  localparam int VALUE_W  = 16;
  localparam int RUN_W    = 8;
  localparam int PEND_W   = 18;
  localparam int FRAC_W   = 8;
  localparam int TOTAL_W  = 16;
  localparam int BYTE_W   = 7;

  // Arithmetic constants
  localparam logic [COUNT_W-1:0] RUN_LIMIT  = 7'd127;
  localparam logic [PEND_W:0]    CLAMP_LOW  = 19'h00300;
  localparam logic [PEND_W:0]    CLAMP_HIGH = 19'h07fff;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 16'hffff;

  // Configuration register map
  localparam logic REG_BOUNDS_IN_USE = 1'b0;
  localparam logic [3:0] BOUNDS_RESET = 4'd3;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_BOUND  = 2'd0,
    KIND_SHIFT  = 2'd1,
    KIND_SYMBOL = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Bound lookup result
  typedef struct packed {
    logic [IDX_W-1:0]    sel;
    logic                matched;
    logic [LENGTH_W-1:0] length;
  } match_t;

endpackage

FILE: rtl/core/pfw_bound_table.sv
module pfw_bound_table (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [pfw_pkg::IDX_W-1:0]    wr_row,
  input  logic [pfw_pkg::COUNT_W-1:0]  wr_count,
  input  logic [pfw_pkg::LENGTH_W-1:0] wr_length,
  input  logic [pfw_pkg::COUNT_W-1:0]  run,
  input  logic [pfw_pkg::CNT_W-1:0]    active,
  output pfw_pkg::match_t              match
);

  logic [pfw_pkg::COUNT_W-1:0]  counts_r  [pfw_pkg::MAX_BOUNDS];
  logic [pfw_pkg::LENGTH_W-1:0] lengths_r [pfw_pkg::MAX_BOUNDS];
  logic [pfw_pkg::IDX_W-1:0]    sel;
  logic                         hit;
  logic [pfw_pkg::CNT_W-1:0]    last;

  // Bound entry writes, no reset: entries are undefined until loaded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      counts_r[wr_row]  <= wr_count;
      lengths_r[wr_row] <= wr_length;
    end
  end

  // Parallel compare, last matching active entry wins
  always_comb begin
    last = active - pfw_pkg::CNT_W'(1);
    sel  = last[pfw_pkg::IDX_W-1:0];
    hit  = 1'b0;
    for (int k = 0; k < pfw_pkg::MAX_BOUNDS; k++) begin
      if ((pfw_pkg::CNT_W'(k) < active) && (counts_r[k] == run)) begin
        sel = pfw_pkg::IDX_W'(k);
        hit = 1'b1;
      end
    end
  end

  assign match.sel     = sel;
  assign match.matched = hit;
  assign match.length  = lengths_r[sel];

endmodule

FILE: rtl/core/precompensated_flux_writer.sv
// Channel | Direction | Contents (low bit up)
// in_     | slave     | tdata: entry_row, entry_column, pattern_count, entry_value,
//         |           |        run_length; tuser: kind
// out_    | master    | tdata: counter_byte, clipped, invalid_symbol, invalid_total
// cfg_    | APB       | 0x0: bounds_in_use (4 bits)
//
// One word per cycle is taken while in_tready is high; a symbol that finds a pulse pending
// has its timer byte valid on out_ after the input register, then bound match plus
// precomp table read into stage 2, then clamp into the result register.
// The 64-entry precomp table is read through a register into stage 2.
// Reset (synchronous, rst_n low) clears the pipeline, the carried pulse and the count.
// A stalled output holds the result; the pipeline keeps filling until every stage
// holds a word, then in_tready drops.
module precompensated_flux_writer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // entry_row[2:0], entry_column[5:3],
                                  // pattern_count[12:6], entry_value[28:13],
                                  // run_length[36:29], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // counter_byte[6:0], clipped[7],
                                  // invalid_symbol[8], invalid_total[24:9], zero pad
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = pfw_pkg::IDX_W;
  localparam int PW = pfw_pkg::PEND_W;

  // Configuration register
  logic [3:0] bounds_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r <= pfw_pkg::BOUNDS_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == pfw_pkg::REG_BOUNDS_IN_USE)) begin
      bounds_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == pfw_pkg::REG_BOUNDS_IN_USE) ? {28'd0, bounds_r} : 32'd0;

  // Active bound count, limited to 1..MAX_BOUNDS
  logic [pfw_pkg::CNT_W-1:0] active;
  always_comb begin
    priority if (bounds_r == 4'd0) begin
      active = pfw_pkg::CNT_W'(1);
    end else if (32'(bounds_r) > pfw_pkg::MAX_BOUNDS) begin
      active = pfw_pkg::CNT_W'(pfw_pkg::MAX_BOUNDS);
    end else begin
      active = pfw_pkg::CNT_W'(bounds_r);
    end
  end

  // Stage 1: input register
  logic                          s1_v_r;
  pfw_pkg::kind_t                s1_kind_r;
  logic [IW-1:0]                 s1_row_r;
  logic [IW-1:0]                 s1_col_r;
  logic [pfw_pkg::COUNT_W-1:0]   s1_count_r;
  logic [pfw_pkg::VALUE_W-1:0]   s1_value_r;
  logic [pfw_pkg::RUN_W-1:0]     s1_run_r;

  // Stage 2: matched symbol with table data
  logic                          s2_v_r;
  logic [pfw_pkg::LENGTH_W-1:0]  s2_len_r;
  logic                          s2_inv_r;
  logic [pfw_pkg::TOTAL_W-1:0]   s2_total_r;
  logic [pfw_pkg::VALUE_W-1:0]   s2_shift_r;

  // Output register
  logic                          out_v_r;
  logic [pfw_pkg::BYTE_W-1:0]    out_byte_r;
  logic                          out_clip_r;
  logic                          out_inv_r;
  logic [pfw_pkg::TOTAL_W-1:0]   out_total_r;

  // Carried state
  logic signed [PW-1:0]          pend_r;
  logic [pfw_pkg::FRAC_W-1:0]    frac_r;
  logic [IW-1:0]                 prevb_r;
  logic [pfw_pkg::TOTAL_W-1:0]   unm_r;
  logic [pfw_pkg::TOTAL_W-1:0]   unm_nxt;

  // Precomp table, row = previous bound, column = current bound
  logic [pfw_pkg::VALUE_W-1:0]   shift_mem [pfw_pkg::MAX_BOUNDS * pfw_pkg::MAX_BOUNDS];

  logic s1_sym, s1_go, s2_emit, s2_go, s2_free, out_free, in_acc;

  // Handshake chain
  assign out_free  = !out_v_r || out_tready;
  assign s2_emit   = (pend_r > PW'(0));
  assign s2_go     = s2_v_r && (!s2_emit || out_free);
  assign s2_free   = !s2_v_r || s2_go;
  assign s1_sym    = (s1_kind_r == pfw_pkg::KIND_SYMBOL);
  assign s1_go     = s1_v_r && (!s1_sym || s2_free);
  assign in_tready = !s1_v_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= pfw_pkg::kind_t'(in_tuser);
      s1_row_r   <= in_tdata[2:0];
      s1_col_r   <= in_tdata[5:3];
      s1_count_r <= in_tdata[12:6];
      s1_value_r <= in_tdata[28:13];
      s1_run_r   <= in_tdata[36:29];
    end
  end

  // Bound lookup on the clipped run length
  logic [pfw_pkg::COUNT_W-1:0] run_clip;
  pfw_pkg::match_t             match;

  assign run_clip = s1_run_r[7] ? pfw_pkg::RUN_LIMIT : s1_run_r[6:0];

  pfw_bound_table u_bounds (
    .clk       (clk),
    .wr_en     (s1_go && (s1_kind_r == pfw_pkg::KIND_BOUND)),
    .wr_row    (s1_row_r),
    .wr_count  (s1_count_r),
    .wr_length (s1_value_r[pfw_pkg::LENGTH_W-1:0]),
    .run       (run_clip),
    .active    (active),
    .match     (match)
  );

  // Precomp table write and registered read
  always_ff @(posedge clk) begin
    if (s1_go && (s1_kind_r == pfw_pkg::KIND_SHIFT)) begin
      shift_mem[{s1_row_r, s1_col_r}] <= s1_value_r;
    end
    if (s1_go && s1_sym) begin
      s2_shift_r <= shift_mem[{prevb_r, match.sel}];
    end
  end

  // Saturating unmatched count
  always_comb begin
    unm_nxt = unm_r;
    if (!match.matched && (unm_r != pfw_pkg::TOTAL_MAX)) begin
      unm_nxt = unm_r + pfw_pkg::TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unm_r   <= '0;
      prevb_r <= '0;
    end else if (s1_go && s1_sym) begin
      unm_r   <= unm_nxt;
      prevb_r <= match.sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_go && s1_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_sym) begin
      s2_len_r   <= match.length;
      s2_inv_r   <= !match.matched;
      s2_total_r <= unm_nxt;
    end
  end

  // Stage 2: move the precomp amount between pulses and clamp
  logic signed [PW:0]          shift_ext;
  logic signed [PW:0]          cur;
  logic signed [PW:0]          diff;
  logic [PW:0]                 val;
  logic                        clip;

  always_comb begin
    shift_ext = (PW+1)'($signed(s2_shift_r));
    cur  = $signed({11'd0, frac_r}) + $signed({4'd0, s2_len_r});
    diff = (PW+1)'(pend_r) - shift_ext;
    if (s2_emit) begin
      cur = cur + shift_ext;
    end
    clip = 1'b0;
    val  = diff;
    priority if (diff < $signed(pfw_pkg::CLAMP_LOW)) begin
      clip = 1'b1;
      val  = pfw_pkg::CLAMP_LOW;
    end else if (diff > $signed(pfw_pkg::CLAMP_HIGH)) begin
      clip = 1'b1;
      val  = pfw_pkg::CLAMP_HIGH;
    end else begin
      val  = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      frac_r <= '0;
    end else if (s2_go) begin
      pend_r <= cur[PW-1:0];
      frac_r <= cur[pfw_pkg::FRAC_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_go && s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_emit) begin
      out_byte_r  <= val[14:8];
      out_clip_r  <= clip;
      out_inv_r   <= s2_inv_r;
      out_total_r <= s2_total_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_total_r, out_inv_r, out_clip_r, out_byte_r};

endmodule

FILE: rtl/core/pfw_checker.sv
module pfw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_pready
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Clamp keeps the timer byte at 3 or above
  a_byte_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] >= 7'd3))
    else $error("timer byte below clamp floor");

  // An unmatched symbol is already in the running total
  a_inv_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> (out_tdata[24:9] != 16'd0))
    else $error("unmatched symbol with zero total");

  // Pad bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:25] == 7'd0))
    else $error("result pad bits set");

  // Config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind precompensated_flux_writer pfw_checker u_pfw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
